// ===== rtl/beq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the biquad cascade equalizer.
// Depends on nothing; every other file of the block imports it.
package beq_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int DELAY_BITS  = 40;
  localparam int GUARD_BITS  = 7;
  localparam int NCOEF       = 5;

  // Derived arithmetic widths
  localparam int PROD_W     = COEF_BITS + SAMPLE_BITS;       // exact Q7.49 product
  localparam int PROD_SHIFT = COEF_BITS - 6 - GUARD_BITS;    // product down to Q.30
  localparam int RND_W      = PROD_W - PROD_SHIFT;           // rounded product
  localparam int SUM_W      = DELAY_BITS + 2;                // three-term sum headroom
  localparam int ACC_W      = DELAY_BITS + 1;
  localparam int YW         = DELAY_BITS - GUARD_BITS + 1;   // Q.23 before saturation

  localparam logic signed [PROD_W-1:0]      PROD_HALF  = PROD_W'(1) << (PROD_SHIFT - 1);
  localparam logic signed [ACC_W-1:0]       GUARD_HALF = ACC_W'(1) << (GUARD_BITS - 1);
  localparam logic        [COEF_BITS-1:0]   COEF_ONE   = COEF_BITS'(1) << (COEF_BITS - 6);
  localparam logic signed [DELAY_BITS-1:0]  DLY_MAX    = {1'b0, {(DELAY_BITS-1){1'b1}}};
  localparam logic signed [DELAY_BITS-1:0]  DLY_MIN    = {1'b1, {(DELAY_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Item modes
  localparam logic MODE_AUDIO = 1'b0;
  localparam logic MODE_COEF  = 1'b1;

  // Coefficient slot that resets to one
  localparam logic [2:0] CI_B0 = 3'd0;

  // Configuration register indexes
  localparam logic CFG_ENABLE   = 1'b0;
  localparam logic CFG_CHAN_CNT = 1'b1;

  // Steps of one cell evaluation; the value also names the coefficient slot read
  typedef enum logic [2:0] {
    STEP_RD = 3'd0,
    STEP_B0 = 3'd1,
    STEP_B1 = 3'd2,
    STEP_B2 = 3'd3,
    STEP_A1 = 3'd4,
    STEP_A2 = 3'd5,
    STEP_WB = 3'd6
  } cell_step_t;

  typedef struct packed {
    logic       active;
    cell_step_t step;
  } cell_ctl_t;

  // Round a full product to Q.30: add half an LSB, floor
  function automatic logic signed [RND_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_HALF;
    return $signed(t[PROD_W-1:PROD_SHIFT]);
  endfunction

  // Round a Q.30 accumulator to Q.23
  function automatic logic signed [YW-1:0] rnd_guard(input logic signed [DELAY_BITS-1:0] a);
    logic signed [ACC_W-1:0] t;
    t = ACC_W'(a) + GUARD_HALF;
    return $signed(t[ACC_W-1:GUARD_BITS]);
  endfunction

  // Saturate a sum to the delay width
  function automatic logic signed [DELAY_BITS-1:0] sat_dly(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(DLY_MAX);
    lo = SUM_W'(DLY_MIN);
    if (v > hi) begin
      return DLY_MAX;
    end else if (v < lo) begin
      return DLY_MIN;
    end else begin
      return $signed(v[DELAY_BITS-1:0]);
    end
  endfunction

  // Saturate a rounded value to the sample width
  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [YW-1:0] v);
    logic signed [YW-1:0] hi;
    logic signed [YW-1:0] lo;
    hi = YW'(SMP_MAX);
    lo = YW'(SMP_MIN);
    if (v > hi) begin
      return SMP_MAX;
    end else if (v < lo) begin
      return SMP_MIN;
    end else begin
      return $signed(v[SAMPLE_BITS-1:0]);
    end
  endfunction

endpackage

// ===== rtl/biquad_cascade_equalizer_core.sv =====
`timescale 1ns / 1ps
// Biquad cascade equalizer: each active channel of an audio frame runs through
// NUM_BANDS transposed direct form II cells whose coefficients and delays sit
// in two synchronous memories. Passthrough bands are skipped and a disabled
// block hands the frame straight to the result; the seven steps per cell and
// channel are set by the single shared multiplier and the one read port of the
// coefficient memory. One item is worked on at a time; the result register
// lets the next item be accepted while a result waits. No clearing pass is
// needed after reset. Depends on beq_pkg and the beq_* modules.
module biquad_cascade_equalizer_core #(
  parameter int NUM_BANDS    = 5,
  parameter int MAX_CHANNELS = 2
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic                                    cfg_index,
  input  logic [1:0]                              cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_mode,
  input  logic signed [beq_pkg::SAMPLE_BITS-1:0]  in_left_sample,
  input  logic signed [beq_pkg::SAMPLE_BITS-1:0]  in_right_sample,
  input  logic                                    in_end_of_block,
  input  logic [2:0]                              in_band_index,
  input  logic [2:0]                              in_coef_index,
  input  logic signed [beq_pkg::COEF_BITS-1:0]    in_coef_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [beq_pkg::SAMPLE_BITS-1:0]  out_left_out,
  output logic signed [beq_pkg::SAMPLE_BITS-1:0]  out_right_out,
  output logic                                    out_end_of_block_out
);
  import beq_pkg::*;

  localparam int BAND_W    = $clog2(NUM_BANDS + 1);
  localparam int BIDX_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int COEF_AW   = $clog2(NUM_BANDS * NCOEF);
  localparam int DLY_DEPTH = NUM_BANDS * MAX_CHANNELS;
  localparam int DLY_AW    = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_CELL = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [BAND_W-1:0]       band_r, band_nxt;
  logic                    ch_r, ch_nxt;
  cell_step_t              step_r, step_nxt;
  logic                    last_ch_r;
  logic                    enable_r;
  logic [1:0]              chan_cnt_r;
  logic signed [SAMPLE_BITS-1:0] smp_r [2];
  logic                    eob_r;
  logic                    out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r;
  logic signed [SAMPLE_BITS-1:0] out_right_r;
  logic                    out_eob_r;

  logic                    in_acc;
  logic                    audio_acc;
  logic                    coef_wr_en;
  logic                    out_load;
  logic [BIDX_W-1:0]       band_idx;
  logic [NUM_BANDS-1:0]    pass;
  logic [COEF_AW-1:0]      coef_rd_addr;
  logic [COEF_BITS-1:0]    coef_rd_data;
  logic [DLY_AW-1:0]       dly_addr;
  logic                    dly_wr_en;
  logic signed [DELAY_BITS-1:0] dly_z1, dly_z2, new_z1, new_z2;
  logic signed [SAMPLE_BITS-1:0] cell_y;
  cell_ctl_t               cell_ctl;
  logic                    cell_last;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign audio_acc  = in_acc && (in_mode == MODE_AUDIO);
  assign coef_wr_en = in_acc && (in_mode == MODE_COEF);
  assign band_idx   = band_r[BIDX_W-1:0];
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign cell_last  = (step_r == STEP_WB) && (ch_r == last_ch_r);

  assign cell_ctl.active = (state_r == ST_CELL);
  assign cell_ctl.step   = step_r;

  assign coef_rd_addr = COEF_AW'(32'(band_r) * NCOEF + 32'(step_r));
  assign dly_addr     = DLY_AW'(32'(band_r) * MAX_CHANNELS + 32'(ch_r));
  assign dly_wr_en    = (state_r == ST_CELL) && (step_r == STEP_WB);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b1;
      chan_cnt_r <= 2'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ENABLE:   enable_r   <= cfg_data[0];
        CFG_CHAN_CNT: chan_cnt_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: walk bands, skip passthrough ones, run each active channel
  always_comb begin
    state_nxt = state_r;
    band_nxt  = band_r;
    ch_nxt    = ch_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (audio_acc) begin
          band_nxt  = '0;
          state_nxt = enable_r ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (band_r == BAND_W'(NUM_BANDS)) begin
          state_nxt = ST_DONE;
        end else if (pass[band_idx]) begin
          band_nxt = band_r + 1'b1;
        end else begin
          state_nxt = ST_CELL;
          ch_nxt    = 1'b0;
          step_nxt  = STEP_RD;
        end
      end
      ST_CELL: begin
        if (step_r == STEP_WB) begin
          step_nxt = STEP_RD;
          if (cell_last) begin
            band_nxt  = band_r + 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            ch_nxt = 1'b1;
          end
        end else begin
          step_nxt = cell_step_t'(step_r + 3'd1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      band_r  <= '0;
      ch_r    <= 1'b0;
      step_r  <= STEP_RD;
    end else begin
      state_r <= state_nxt;
      band_r  <= band_nxt;
      ch_r    <= ch_nxt;
      step_r  <= step_nxt;
    end
  end

  // Frame samples: load on acceptance, replace with each cell output
  always_ff @(posedge clk) begin
    if (audio_acc) begin
      smp_r[0]  <= in_left_sample;
      smp_r[1]  <= in_right_sample;
      eob_r     <= in_end_of_block;
      last_ch_r <= (MAX_CHANNELS > 1) && (chan_cnt_r > 2'd1);
    end else if (dly_wr_en) begin
      smp_r[ch_r] <= cell_y;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= smp_r[0];
      out_right_r <= smp_r[1];
      out_eob_r   <= eob_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_left_out         = out_left_r;
  assign out_right_out        = out_right_r;
  assign out_end_of_block_out = out_eob_r;

  beq_coef_mem #(
    .NUM_BANDS (NUM_BANDS)
  ) u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (coef_wr_en),
    .wr_band (in_band_index),
    .wr_k    (in_coef_index),
    .wr_data (in_coef_value),
    .rd_addr (coef_rd_addr),
    .rd_k    (step_r),
    .rd_data (coef_rd_data),
    .pass    (pass)
  );

  beq_delay_mem #(
    .DEPTH (DLY_DEPTH)
  ) u_dly (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (dly_addr),
    .rd_z1   (dly_z1),
    .rd_z2   (dly_z2),
    .wr_en   (dly_wr_en),
    .wr_addr (dly_addr),
    .wr_z1   (new_z1),
    .wr_z2   (new_z2)
  );

  beq_cell_dp u_dp (
    .clk    (clk),
    .ctl    (cell_ctl),
    .coef   (coef_rd_data),
    .x      (smp_r[ch_r]),
    .z1_in  (dly_z1),
    .z2_in  (dly_z2),
    .y      (cell_y),
    .z1_out (new_z1),
    .z2_out (new_z2)
  );

  // A result appears only out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

  // A pending result is never overwritten
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && out_stall |=> (state_r == ST_DONE))
    else $error("done state left while result stalled");

  // Delays of a passthrough band never move
  a_no_skip_write: assert property (@(posedge clk) disable iff (!rst_n)
    dly_wr_en |-> !pass[band_idx])
    else $error("delay written for passthrough band");

  // Cells run only on bands that exist
  a_cell_band: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CELL) |-> (band_r < BAND_W'(NUM_BANDS)))
    else $error("cell on band out of range");

  // The right channel is touched only in stereo
  a_mono_right: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CELL) |-> (!ch_r || last_ch_r))
    else $error("right channel filtered in mono");

endmodule

// ===== rtl/beq_coef_mem.sv =====
`timescale 1ns / 1ps
// Coefficient store: one synchronous memory of NCOEF words per band plus a
// per-word match flag that stands for the reset value. Depends on beq_pkg.
module beq_coef_mem #(
  parameter int NUM_BANDS = 5,
  localparam int AW = $clog2(NUM_BANDS * beq_pkg::NCOEF)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [2:0]                     wr_band,
  input  logic [2:0]                     wr_k,
  input  logic [beq_pkg::COEF_BITS-1:0]  wr_data,
  input  logic [AW-1:0]                  rd_addr,
  input  logic [2:0]                     rd_k,
  output logic [beq_pkg::COEF_BITS-1:0]  rd_data,
  output logic [NUM_BANDS-1:0]           pass
);
  import beq_pkg::*;

  localparam int DEPTH = NUM_BANDS * NCOEF;

  logic [COEF_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     match_r;
  logic [COEF_BITS-1:0] mem_q;
  logic                 match_q;
  logic                 k0_q;
  logic                 wr_ok;
  logic [AW-1:0]        wr_addr;
  logic                 wr_match;

  // Drop writes outside the table
  assign wr_ok   = wr_en && (32'(wr_band) < NUM_BANDS) && (32'(wr_k) < NCOEF);
  assign wr_addr = AW'(32'(wr_band) * NCOEF + 32'(wr_k));
  assign wr_match = (wr_k == CI_B0) ? (wr_data == COEF_ONE) : (wr_data == '0);

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // Flag words that hold their reset value; a flagged word never reads the array
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= '1;
    end else if (wr_ok) begin
      match_r[wr_addr] <= wr_match;
    end
  end

  always_ff @(posedge clk) begin
    match_q <= match_r[rd_addr];
    k0_q    <= (rd_k == CI_B0);
  end

  assign rd_data = match_q ? (k0_q ? COEF_ONE : '0) : mem_q;

  // A band is passthrough when all its words hold the reset value
  for (genvar b = 0; b < NUM_BANDS; b++) begin : g_pass
    assign pass[b] = &match_r[b*NCOEF +: NCOEF];
  end

endmodule

// ===== rtl/beq_delay_mem.sv =====
`timescale 1ns / 1ps
// Delay store: both delay values of one band and channel in one word of a
// synchronous memory, with a valid bit per word. Depends on beq_pkg.
module beq_delay_mem #(
  parameter int DEPTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [AW-1:0]                          rd_addr,
  output logic signed [beq_pkg::DELAY_BITS-1:0]  rd_z1,
  output logic signed [beq_pkg::DELAY_BITS-1:0]  rd_z2,
  input  logic                                   wr_en,
  input  logic [AW-1:0]                          wr_addr,
  input  logic signed [beq_pkg::DELAY_BITS-1:0]  wr_z1,
  input  logic signed [beq_pkg::DELAY_BITS-1:0]  wr_z2
);
  import beq_pkg::*;

  logic [2*DELAY_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        vld_r;
  logic [2*DELAY_BITS-1:0] mem_q;
  logic                    vld_q;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_z1, wr_z2};
    end
    mem_q <= mem[rd_addr];
  end

  // Words never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q <= vld_r[rd_addr];
  end

  assign rd_z1 = vld_q ? $signed(mem_q[2*DELAY_BITS-1:DELAY_BITS]) : '0;
  assign rd_z2 = vld_q ? $signed(mem_q[DELAY_BITS-1:0]) : '0;

endmodule

// ===== rtl/beq_cell_dp.sv =====
`timescale 1ns / 1ps
// Cell datapath: one shared multiplier with a product register, stepping
// through the five products of a transposed direct form II cell. Depends on beq_pkg.
module beq_cell_dp (
  input  logic                                    clk,
  input  beq_pkg::cell_ctl_t                      ctl,
  input  logic [beq_pkg::COEF_BITS-1:0]           coef,
  input  logic signed [beq_pkg::SAMPLE_BITS-1:0]  x,
  input  logic signed [beq_pkg::DELAY_BITS-1:0]   z1_in,
  input  logic signed [beq_pkg::DELAY_BITS-1:0]   z2_in,
  output logic signed [beq_pkg::SAMPLE_BITS-1:0]  y,
  output logic signed [beq_pkg::DELAY_BITS-1:0]   z1_out,
  output logic signed [beq_pkg::DELAY_BITS-1:0]   z2_out
);
  import beq_pkg::*;

  logic signed [PROD_W-1:0]      prod_r;
  logic signed [PROD_W-1:0]      mul_full;
  logic signed [SAMPLE_BITS-1:0] opnd;
  logic signed [RND_W-1:0]       prod_rnd;
  logic signed [DELAY_BITS-1:0]  z1_r;
  logic signed [DELAY_BITS-1:0]  z2_r;
  logic signed [DELAY_BITS-1:0]  acc_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic signed [RND_W-1:0]       t1_r;
  logic signed [RND_W-1:0]       t2_r;
  logic signed [DELAY_BITS-1:0]  z1n_r;
  logic signed [SUM_W-1:0]       acc_sum;
  logic signed [SUM_W-1:0]       z1_sum;
  logic signed [SUM_W-1:0]       z2_sum;

  // Feed-forward products take the input, feedback products the cell output
  assign opnd     = (ctl.step == STEP_A1 || ctl.step == STEP_A2) ? y_r : x;
  assign mul_full = $signed(coef) * opnd;
  assign prod_rnd = rnd_prod(prod_r);

  assign acc_sum = SUM_W'(prod_rnd) + SUM_W'(z1_r);
  assign z1_sum  = SUM_W'(t1_r) - SUM_W'(prod_rnd) + SUM_W'(z2_r);
  assign z2_sum  = SUM_W'(t2_r) - SUM_W'(prod_rnd);

  // Step through one cell
  always_ff @(posedge clk) begin
    if (ctl.active) begin
      case (ctl.step)
        STEP_B0: begin
          prod_r <= mul_full;
          z1_r   <= z1_in;
          z2_r   <= z2_in;
        end
        STEP_B1: begin
          acc_r  <= sat_dly(acc_sum);
          prod_r <= mul_full;
        end
        STEP_B2: begin
          y_r    <= sat_smp(rnd_guard(acc_r));
          t1_r   <= prod_rnd;
          prod_r <= mul_full;
        end
        STEP_A1: begin
          t2_r   <= prod_rnd;
          prod_r <= mul_full;
        end
        STEP_A2: begin
          z1n_r  <= sat_dly(z1_sum);
          prod_r <= mul_full;
        end
        default: begin
        end
      endcase
    end
  end

  assign y      = y_r;
  assign z1_out = z1n_r;
  assign z2_out = sat_dly(z2_sum);

endmodule
